### sv/shortest_job_next_scheduler_assert.svh
// Assertion macros used by the checker of the scheduler.
`ifndef SHORTEST_JOB_NEXT_SCHEDULER_ASSERT_SVH
`define SHORTEST_JOB_NEXT_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SJN_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("shortest_job_next_scheduler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SJN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("shortest_job_next_scheduler: next-cycle check failed");

`endif

### sv/sjn_pkg.sv
package sjn_pkg;

   // Sizing of the ready queue and of the time and burst counters.
   localparam int QUEUE_DEPTH = 16;
   localparam int BURST_BITS  = 16;
   localparam int TIME_BITS   = 32;

   localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths of the channels.
   localparam int ID_BITS       = 8;
   localparam int IN_BURST_BITS = 16;
   localparam int OUT_BITS      = 32;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 136;

   typedef enum logic {
      OP_ARRIVE,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      EV_COMPLETE,
      EV_DISPATCH,
      EV_REJECT
   } event_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REJECT,
      ST_COMPLETE,
      ST_SCAN,
      ST_DISPATCH,
      ST_ADVANCE
   } state_type;

   // One queued job.
   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [BURST_BITS-1:0] burst;
      logic [TIME_BITS-1:0]  arrival;
   } entry_type;

   // Best job seen so far while the search moves along the chain.
   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   idx;
      entry_type             entry;
   } cand_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic active;
      logic load;
      logic shift;
   } cell_ctrl_type;

   localparam cand_type CAND_NONE = '0;

endpackage

### sv/sjn_cell.sv
module sjn_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  sjn_pkg::cell_ctrl_type        ctrl,
   input  logic [sjn_pkg::IDX_BITS-1:0]  cell_idx,
   input  sjn_pkg::entry_type            new_entry,
   input  sjn_pkg::entry_type            right_entry,
   input  sjn_pkg::cand_type             left_cand,
   output sjn_pkg::entry_type            entry_out,
   output sjn_pkg::cand_type             cand_out
);

   sjn_pkg::entry_type entry_ff, entry_in;
   sjn_pkg::cand_type  cand_ff, cand_in;

   // The slot takes a new job at the tail, or its right neighbor when a job leaves.
   always_comb begin
      if (ctrl.load) begin
         entry_in = new_entry;
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Keep the left candidate unless this active slot holds a strictly shorter job.
   always_comb begin
      if (ctrl.active && (!left_cand.found || (entry_ff.burst < left_cand.entry.burst))) begin
         cand_in.found = 1'b1;
         cand_in.idx   = cell_idx;
         cand_in.entry = entry_ff;
      end else begin
         cand_in = left_cand;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.found <= 1'b0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   assign entry_out = entry_ff;
   assign cand_out  = cand_ff;

endmodule

### sv/shortest_job_next_scheduler.sv
// Non-preemptive shortest-job-next scheduler.
// The req channel carries one item per transfer: req_tuser selects arrive or tick, and
// req_tdata holds the job id and burst length of an arriving job. The rsp channel carries
// events: completion, dispatch or rejection, with rsp_tlast on the final event of an item.
// An arrive gives no event unless the queue is full; a rejection is then emitted from the
// reject state once the output register is free. A tick first reports any completion, then,
// if a job must be dispatched, runs the search for the shortest job waiting in the queue
// along the chain of QUEUE_DEPTH cells, one cell per cycle, and reports the dispatch.
// A new transfer is taken only in the idle state, once the previous item is through.
// The chain length sets how long the search runs, as the candidate visits every cell.
// Reset clears time, the queue count and the running job; the queue slots themselves are
// not cleared, since only occupied slots are ever read.
// Events wait in an output register; when the receiver stalls, an item that must emit
// an event waits for it, while a result already waiting does not stop a new transfer.
module shortest_job_next_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] job_id, [23:8] burst_time
   input  logic [sjn_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [0] operation
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] job_id_out, [39:8] event_time, [71:40] turnaround, [103:72] waiting,
   // [135:104] response
   output logic [sjn_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [1:0] event_kind
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   sjn_pkg::state_type state_ff, state_in;

   logic [sjn_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [sjn_pkg::TIME_BITS-1:0]  time_ff, time_in;
   logic                           busy_ff, busy_in;
   logic [sjn_pkg::ID_BITS-1:0]    run_id_ff, run_id_in;
   logic [sjn_pkg::BURST_BITS-1:0] run_left_ff, run_left_in;
   logic [sjn_pkg::TIME_BITS-1:0]  run_arrival_ff, run_arrival_in;
   logic [sjn_pkg::TIME_BITS-1:0]  run_due_ff, run_due_in;
   logic [sjn_pkg::ID_BITS-1:0]    req_id_ff, req_id_in;
   logic [sjn_pkg::IDX_BITS-1:0]   scan_cnt_ff, scan_cnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   sjn_pkg::event_kind_type        rsp_kind_ff, rsp_kind_in;
   logic [sjn_pkg::ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [sjn_pkg::OUT_BITS-1:0]   rsp_time_ff, rsp_time_in;
   logic [sjn_pkg::OUT_BITS-1:0]   rsp_tr_ff, rsp_tr_in;
   logic [sjn_pkg::OUT_BITS-1:0]   rsp_wt_ff, rsp_wt_in;
   logic [sjn_pkg::OUT_BITS-1:0]   rsp_rs_ff, rsp_rs_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic req_accept, slot_free, done_job, have_job, queue_full;
   logic do_load, do_shift, clr_busy, set_run, do_adv;
   logic emit, emit_last;
   sjn_pkg::event_kind_type        emit_kind;
   logic [sjn_pkg::ID_BITS-1:0]    emit_id;
   logic [sjn_pkg::TIME_BITS-1:0]  turn_full, wait_full, resp_full;

   sjn_pkg::entry_type             arrive_entry;
   sjn_pkg::entry_type             cell_entry [sjn_pkg::QUEUE_DEPTH];
   sjn_pkg::cand_type              cell_cand  [sjn_pkg::QUEUE_DEPTH];
   sjn_pkg::cand_type              best;

   // Handshake and status terms.
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign done_job   = busy_ff && (run_left_ff == '0);
   assign have_job   = (count_ff != '0);
   assign queue_full = (count_ff >= sjn_pkg::CNT_BITS'(sjn_pkg::QUEUE_DEPTH));
   assign best       = cell_cand[sjn_pkg::QUEUE_DEPTH-1];

   // Job written at the tail on an arrive.
   assign arrive_entry.id      = req_tdata[sjn_pkg::ID_BITS-1:0];
   assign arrive_entry.burst   = sjn_pkg::BURST_BITS'(
      req_tdata[sjn_pkg::ID_BITS +: sjn_pkg::IN_BURST_BITS]);
   assign arrive_entry.arrival = time_ff;

   // Chain of queue cells; the search candidate moves one cell to the right each cycle.
   for (genvar i = 0; i < sjn_pkg::QUEUE_DEPTH; i++) begin : g_cell
      sjn_pkg::cell_ctrl_type ctrl;
      sjn_pkg::cand_type      left_cand;
      sjn_pkg::entry_type     right_entry;

      assign ctrl.active = (sjn_pkg::CNT_BITS'(i) < count_ff);
      assign ctrl.load   = do_load && (sjn_pkg::CNT_BITS'(i) == count_ff);
      assign ctrl.shift  = do_shift && (sjn_pkg::IDX_BITS'(i) >= best.idx);

      if (i == 0) begin : g_head
         assign left_cand = sjn_pkg::CAND_NONE;
      end else begin : g_link
         assign left_cand = cell_cand[i-1];
      end

      if (i == sjn_pkg::QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_next
         assign right_entry = cell_entry[i+1];
      end

      sjn_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cell_idx    (sjn_pkg::IDX_BITS'(i)),
         .new_entry   (arrive_entry),
         .right_entry (right_entry),
         .left_cand   (left_cand),
         .entry_out   (cell_entry[i]),
         .cand_out    (cell_cand[i])
      );
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sjn_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == sjn_pkg::OP_TICK) begin
                  state_in = sjn_pkg::ST_COMPLETE;
               end else if (queue_full) begin
                  state_in = sjn_pkg::ST_REJECT;
               end
            end
         end
         sjn_pkg::ST_REJECT: begin
            if (slot_free) begin
               state_in = sjn_pkg::ST_IDLE;
            end
         end
         sjn_pkg::ST_COMPLETE: begin
            if (done_job) begin
               if (slot_free) begin
                  state_in = have_job ? sjn_pkg::ST_SCAN : sjn_pkg::ST_ADVANCE;
               end
            end else if (!busy_ff && have_job) begin
               state_in = sjn_pkg::ST_SCAN;
            end else begin
               state_in = sjn_pkg::ST_ADVANCE;
            end
         end
         sjn_pkg::ST_SCAN: begin
            if (scan_cnt_ff == sjn_pkg::IDX_BITS'(sjn_pkg::QUEUE_DEPTH - 1)) begin
               state_in = sjn_pkg::ST_DISPATCH;
            end
         end
         sjn_pkg::ST_DISPATCH: begin
            if (slot_free) begin
               state_in = sjn_pkg::ST_ADVANCE;
            end
         end
         sjn_pkg::ST_ADVANCE: begin
            state_in = sjn_pkg::ST_IDLE;
         end
         default: begin
            state_in = sjn_pkg::ST_IDLE;
         end
      endcase
   end

   // Event arithmetic, modulo the time width.
   assign turn_full = time_ff - run_arrival_ff;
   assign wait_full = time_ff - run_due_ff;
   assign resp_full = time_ff - best.entry.arrival;

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      do_load    = 1'b0;
      do_shift   = 1'b0;
      clr_busy   = 1'b0;
      set_run    = 1'b0;
      do_adv     = 1'b0;
      emit       = 1'b0;
      emit_kind  = sjn_pkg::EV_COMPLETE;
      emit_id    = run_id_ff;
      emit_last  = 1'b1;
      case (state_ff)
         sjn_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            do_load    = req_accept && (req_tuser == sjn_pkg::OP_ARRIVE) && !queue_full;
         end
         sjn_pkg::ST_REJECT: begin
            emit      = slot_free;
            emit_kind = sjn_pkg::EV_REJECT;
            emit_id   = req_id_ff;
         end
         sjn_pkg::ST_COMPLETE: begin
            emit      = done_job && slot_free;
            clr_busy  = done_job && slot_free;
            emit_kind = sjn_pkg::EV_COMPLETE;
            emit_id   = run_id_ff;
            emit_last = !have_job;
         end
         sjn_pkg::ST_SCAN: begin
         end
         sjn_pkg::ST_DISPATCH: begin
            emit      = slot_free;
            do_shift  = slot_free;
            set_run   = slot_free;
            emit_kind = sjn_pkg::EV_DISPATCH;
            emit_id   = best.entry.id;
         end
         sjn_pkg::ST_ADVANCE: begin
            do_adv = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next values of the scheduler state.
   always_comb begin
      count_in       = count_ff;
      time_in        = time_ff;
      busy_in        = busy_ff;
      run_id_in      = run_id_ff;
      run_left_in    = run_left_ff;
      run_arrival_in = run_arrival_ff;
      run_due_in     = run_due_ff;
      req_id_in      = req_accept ? req_tdata[sjn_pkg::ID_BITS-1:0] : req_id_ff;
      scan_cnt_in    = (state_ff == sjn_pkg::ST_SCAN) ? scan_cnt_ff + 1'b1 : '0;

      if (do_load) begin
         count_in = count_ff + 1'b1;
      end else if (do_shift) begin
         count_in = count_ff - 1'b1;
      end

      if (clr_busy) begin
         busy_in = 1'b0;
      end else if (set_run) begin
         busy_in        = 1'b1;
         run_id_in      = best.entry.id;
         run_left_in    = best.entry.burst;
         run_arrival_in = best.entry.arrival;
         run_due_in     = best.entry.arrival + sjn_pkg::TIME_BITS'(best.entry.burst);
      end

      if (do_adv) begin
         time_in = time_ff + 1'b1;
         if (busy_ff && (run_left_ff != '0)) begin
            run_left_in = run_left_ff - 1'b1;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_tr_in    = rsp_tr_ff;
      rsp_wt_in    = rsp_wt_ff;
      rsp_rs_in    = rsp_rs_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_kind_in = emit_kind;
         rsp_id_in   = emit_id;
         rsp_time_in = sjn_pkg::OUT_BITS'(time_ff);
         rsp_last_in = emit_last;
         rsp_tr_in   = '0;
         rsp_wt_in   = '0;
         rsp_rs_in   = '0;
         if (emit_kind == sjn_pkg::EV_COMPLETE) begin
            rsp_tr_in = sjn_pkg::OUT_BITS'(turn_full);
            rsp_wt_in = sjn_pkg::OUT_BITS'(wait_full);
         end else if (emit_kind == sjn_pkg::EV_DISPATCH) begin
            rsp_rs_in = sjn_pkg::OUT_BITS'(resp_full);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sjn_pkg::ST_IDLE;
         count_ff       <= '0;
         time_ff        <= '0;
         busy_ff        <= 1'b0;
         run_id_ff      <= '0;
         run_left_ff    <= '0;
         run_arrival_ff <= '0;
         run_due_ff     <= '0;
         scan_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         time_ff        <= time_in;
         busy_ff        <= busy_in;
         run_id_ff      <= run_id_in;
         run_left_ff    <= run_left_in;
         run_arrival_ff <= run_arrival_in;
         run_due_ff     <= run_due_in;
         scan_cnt_ff    <= scan_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_id_ff   <= req_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_time_ff <= rsp_time_in;
      rsp_tr_ff   <= rsp_tr_in;
      rsp_wt_ff   <= rsp_wt_in;
      rsp_rs_ff   <= rsp_rs_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_rs_ff, rsp_wt_ff, rsp_tr_ff, rsp_time_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/sjn_checker.sv
`include "shortest_job_next_scheduler_assert.svh"

module sjn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sjn_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [1:0]                         rsp_tuser,
   input logic                               rsp_tlast
);

   logic [31:0] turnaround, waiting, response;
   logic [sjn_pkg::RSP_DATA_BITS+2:0] rsp_word;
   logic rsp_stall, is_reject, is_dispatch, is_complete, no_timing;

   assign turnaround  = rsp_tdata[71:40];
   assign waiting     = rsp_tdata[103:72];
   assign response    = rsp_tdata[135:104];
   assign rsp_word    = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign is_reject   = rsp_tvalid && (rsp_tuser == sjn_pkg::EV_REJECT);
   assign is_dispatch = rsp_tvalid && (rsp_tuser == sjn_pkg::EV_DISPATCH);
   assign is_complete = rsp_tvalid && (rsp_tuser == sjn_pkg::EV_COMPLETE);
   assign no_timing   = (turnaround == '0) && (waiting == '0);

   // A stalled event keeps its contents.
   `SJN_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // A rejection is the only event of its arrive and carries no timing figures.
   `SJN_ASSERT_NOW(a_reject_last, is_reject, rsp_tlast && no_timing && (response == '0))

   // A dispatch always closes the events of its tick.
   `SJN_ASSERT_NOW(a_dispatch_last, is_dispatch, rsp_tlast && no_timing)

   // A completion has no response figure, and waiting never exceeds turnaround.
   `SJN_ASSERT_NOW(a_complete_fields, is_complete, (response == '0) && (waiting <= turnaround))

endmodule

bind shortest_job_next_scheduler sjn_checker u_sjn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
